/* rtl/lce_pkg.sv */
// Shared types and constants for the expiring LRU cache.
// Used by lce_cmp, the top level and the checker; no dependencies.
`default_nettype none
package lce_pkg;
   localparam int N_SLOTS = 16;
   localparam int SLOT_W  = $clog2(N_SLOTS);
   localparam int CNT_W   = $clog2(N_SLOTS + 1);
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int TTL_W   = 32;
   localparam int TIME_W  = 48;
   localparam int CAP_W   = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(N_SLOTS);
   localparam logic REQ_GET    = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic expired;
      logic key_match;
   } cmp_res_type;
endpackage
`default_nettype wire

/* rtl/lce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/lce_cmp.sv */
// Shared compare unit: expiry check and key match for one scanned slot.
// Depends on lce_pkg.
`default_nettype none
module lce_cmp (
   input  wire lce_pkg::entry_type             entry,
   input  wire logic [lce_pkg::TIME_W-1:0]     now_time,
   input  wire logic [lce_pkg::KEY_W-1:0]      lookup_key,
   output lce_pkg::cmp_res_type                res
);
   import lce_pkg::*;

   assign res.expired   = (entry.expiry <= now_time);
   assign res.key_match = (entry.key == lookup_key);
endmodule
`default_nettype wire

/* rtl/lru_cache_with_expiry.sv */
// Top level of the expiring LRU cache: sequencer, valid/rank state, outputs.
// Depends on lce_pkg, lce_ram and lce_cmp.
//
// Usage:
//   Request: drive req_* and pulse start while busy is low; the transaction is
//   taken at that edge and busy rises the next cycle.
//   Each request scans all 16 slots once through the shared compare unit
//   (purging expired entries and matching the key), one slot per cycle.
//   An insert of a new key then walks the slots again to find the LRU entry
//   and a free slot.
//   busy falls in the cycle rsp_valid is high, so the next start may be
//   taken there.
//   Response: rsp_* hold the result for the single cycle rsp_valid is high.
//   The receiver cannot stall; it must take the transaction in that cycle.
//   Configuration: csr_we writes csr_wdata (capacity); the user must assert it
//   only while idle, as the block itself leaves this unchecked.
//   Reset: synchronous, clears all entries; capacity returns to 16.
`default_nettype none
module lru_cache_with_expiry (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic [lce_pkg::KEY_W-1:0]    req_lookup_key,
   input  wire logic [lce_pkg::VAL_W-1:0]    req_write_value,
   input  wire logic [lce_pkg::TTL_W-1:0]    req_time_to_live,
   input  wire logic [lce_pkg::TIME_W-1:0]   req_now_time,
   input  wire logic                         csr_we,
   input  wire logic [lce_pkg::CAP_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic      [lce_pkg::VAL_W-1:0]    rsp_read_value,
   output logic                              rsp_lru_evicted,
   output logic      [lce_pkg::CNT_W-1:0]    rsp_expired_removed,
   output logic      [lce_pkg::CNT_W-1:0]    rsp_live_count
);
   import lce_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FIND  = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              type_ff, type_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] exp_ff, exp_in;
   logic              valid_ff [N_SLOTS];
   logic              valid_in [N_SLOTS];
   logic [SLOT_W-1:0] rank_ff [N_SLOTS];
   logic [SLOT_W-1:0] rank_in [N_SLOTS];
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [VAL_W-1:0]  rdv_ff, rdv_in;
   logic [CNT_W-1:0]  removed_ff, removed_in;
   logic [SLOT_W-1:0] lru_ff, lru_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic              free_ok_ff, free_ok_in;
   logic              rv_ff, rv_in;
   logic              hit_ff, hit_in;
   logic [VAL_W-1:0]  rval_ff, rval_in;
   logic              evict_ff, evict_in;

   logic [TIME_W:0]   exp_sum;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] idx;
   logic [SLOT_W-1:0] fidx;
   logic [SLOT_W-1:0] tgt;
   logic [SLOT_W-1:0] hit_rank;
   logic [SLOT_W-1:0] lru_rank;
   logic [CAP_W-1:0]  cap_eff;
   logic              evict;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;
   cmp_res_type       cmp;

   lce_ram #(.WIDTH(ENTRY_W), .DEPTH(N_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lce_cmp u_cmp (
      .entry      (rd_data),
      .now_time   (now_ff),
      .lookup_key (key_ff),
      .res        (cmp)
   );

   assign exp_sum  = {1'b0, req_now_time} + {{(TIME_W + 1 - TTL_W){1'b0}}, req_time_to_live};
   assign rd_addr  = cnt_ff[SLOT_W-1:0];
   assign idx      = SLOT_W'(cnt_ff - CNT_W'(1));
   assign fidx     = cnt_ff[SLOT_W-1:0];
   assign hit_rank = rank_ff[slot_ff];
   assign lru_rank = SLOT_W'(occ_ff - CNT_W'(1));
   assign cap_eff  = (cap_ff == '0) ? CAP_W'(1) :
                     (cap_ff > CAP_W'(N_SLOTS)) ? CAP_W'(N_SLOTS) : cap_ff;
   assign evict    = (CAP_W'(occ_ff) >= cap_eff);
   // the evicted slot is free too; take the lowest free index
   assign tgt      = (evict && (!free_ok_ff || lru_ff < free_ff)) ? lru_ff : free_ff;

   assign wr_en        = (state_ff == ST_APPLY) && (type_ff == REQ_INSERT);
   assign wr_addr      = found_ff ? slot_ff : tgt;
   assign wr_data.key    = key_ff;
   assign wr_data.value  = val_ff;
   assign wr_data.expiry = exp_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      type_in    = type_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      now_in     = now_ff;
      exp_in     = exp_ff;
      valid_in   = valid_ff;
      rank_in    = rank_ff;
      occ_in     = occ_ff;
      cap_in     = csr_we ? csr_wdata : cap_ff;
      found_in   = found_ff;
      slot_in    = slot_ff;
      rdv_in     = rdv_ff;
      removed_in = removed_ff;
      lru_in     = lru_ff;
      free_in    = free_ff;
      free_ok_in = free_ok_ff;
      rv_in      = 1'b0;
      hit_in     = hit_ff;
      rval_in    = rval_ff;
      evict_in   = evict_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_SCAN;
               cnt_in     = '0;
               type_in    = req_type;
               key_in     = req_lookup_key;
               val_in     = req_write_value;
               now_in     = req_now_time;
               exp_in     = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
               found_in   = 1'b0;
               removed_in = '0;
               free_ok_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0 && valid_ff[idx]) begin
               if (cmp.expired) begin
                  valid_in[idx] = 1'b0;
                  for (int i = 0; i < N_SLOTS; i++) begin
                     if (valid_ff[i] && rank_ff[i] > rank_ff[idx]) begin
                        rank_in[i] = rank_ff[i] - SLOT_W'(1);
                     end
                  end
                  occ_in     = occ_ff - CNT_W'(1);
                  removed_in = removed_ff + CNT_W'(1);
               end else if (cmp.key_match && !found_ff) begin
                  found_in = 1'b1;
                  slot_in  = idx;
                  rdv_in   = rd_data.value;
               end
            end
            if (cnt_ff == CNT_W'(N_SLOTS)) begin
               cnt_in   = '0;
               state_in = (type_ff == REQ_INSERT && !found_in) ? ST_FIND : ST_APPLY;
            end
         end
         ST_FIND: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (valid_ff[fidx] && rank_ff[fidx] == lru_rank) begin
               lru_in = fidx;
            end
            if (!valid_ff[fidx] && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = fidx;
            end
            if (fidx == SLOT_W'(N_SLOTS - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            rv_in    = 1'b1;
            hit_in   = found_ff || (type_ff == REQ_INSERT);
            rval_in  = (found_ff && type_ff == REQ_GET) ? rdv_ff : '0;
            evict_in = 1'b0;
            if (found_ff) begin
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                     rank_in[i] = rank_ff[i] + SLOT_W'(1);
                  end
               end
               rank_in[slot_ff] = '0;
            end else if (type_ff == REQ_INSERT) begin
               evict_in = evict;
               // evicted entry had the top rank, so survivors just age by one
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + SLOT_W'(1);
                  end
               end
               if (evict) begin
                  valid_in[lru_ff] = 1'b0;
               end
               valid_in[tgt] = 1'b1;
               rank_in[tgt]  = '0;
               occ_in = evict ? occ_ff : occ_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
         rv_ff    <= 1'b0;
         for (int i = 0; i < N_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
         rv_ff    <= rv_in;
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      cnt_ff     <= cnt_in;
      type_ff    <= type_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      now_ff     <= now_in;
      exp_ff     <= exp_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      rdv_ff     <= rdv_in;
      removed_ff <= removed_in;
      lru_ff     <= lru_in;
      free_ff    <= free_in;
      free_ok_ff <= free_ok_in;
      hit_ff     <= hit_in;
      rval_ff    <= rval_in;
      evict_ff   <= evict_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rv_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_read_value      = rval_ff;
   assign rsp_lru_evicted     = evict_ff;
   assign rsp_expired_removed = removed_ff;
   assign rsp_live_count      = occ_ff;
endmodule
`default_nettype wire

/* rtl/lce_checker.sv */
// Port-level assertions for the expiring LRU cache, bound to the top level.
// Depends on lce_pkg.
`default_nettype none
module lce_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_type,
   input wire logic [lce_pkg::KEY_W-1:0]    req_lookup_key,
   input wire logic [lce_pkg::VAL_W-1:0]    req_write_value,
   input wire logic [lce_pkg::TTL_W-1:0]    req_time_to_live,
   input wire logic [lce_pkg::TIME_W-1:0]   req_now_time,
   input wire logic                         csr_we,
   input wire logic [lce_pkg::CAP_W-1:0]    csr_wdata,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_hit,
   input wire logic [lce_pkg::VAL_W-1:0]    rsp_read_value,
   input wire logic                         rsp_lru_evicted,
   input wire logic [lce_pkg::CNT_W-1:0]    rsp_expired_removed,
   input wire logic [lce_pkg::CNT_W-1:0]    rsp_live_count
);
   import lce_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy fell without a response");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_count <= CNT_W'(N_SLOTS)
                 && rsp_expired_removed <= CNT_W'(N_SLOTS))
      else $error("count out of range");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0 && !rsp_lru_evicted)
      else $error("miss carries data or eviction");
endmodule

bind lru_cache_with_expiry lce_checker u_lce_checker (.*);
`default_nettype wire
